/* rtl/cice_pkg.sv */
package cice_pkg;

    localparam int SEQ_ID_BITS = 12;
    localparam int BASE_SHIFT  = 14;
    localparam int N_LVLS      = 8;
    localparam int POS_BITS    = BASE_SHIFT + 3 * N_LVLS;
    localparam int CNT_BITS    = 48;
    localparam int BIN_BITS    = 25;
    localparam int OFF_BITS    = 64;
    localparam int SEQ_BITS    = 12;
    localparam int MAX_CHUNKS  = 3;
    localparam int CNT_IDX_BITS = $clog2(MAX_CHUNKS + 1);

    localparam logic [BIN_BITS-1:0] PSEUDO_BIN = 25'd19173962;
    localparam logic [SEQ_BITS-1:0] SEQ_MASK =
        SEQ_BITS'((64'd1 << SEQ_ID_BITS) - 64'd1);
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [SEQ_BITS-1:0]       seq_id;
        logic signed [39:0]        reg_start;
        logic signed [39:0]        reg_end;
        logic [OFF_BITS-1:0]       rec_offset;
    } t_in_item;

    typedef struct packed {
        logic [SEQ_BITS-1:0]       chunk_seq;
        logic [BIN_BITS-1:0]       chunk_bin;
        logic [OFF_BITS-1:0]       chunk_beg;
        logic [OFF_BITS-1:0]       chunk_end;
        logic                      last_of_run;
    } t_out_item;

    function automatic logic [BIN_BITS-1:0] bin_offset(input int lvl);
        logic [BIN_BITS-1:0] acc;
        logic [BIN_BITS-1:0] pw;
        acc = '0;
        pw  = BIN_BITS'(1);
        for (int i = 0; i < lvl; i++) begin
            acc = acc + pw;
            pw  = BIN_BITS'(pw << 3);
        end
        return acc;
    endfunction

endpackage

/* rtl/cice_bin_calc.sv */
module cice_bin_calc (
    input  logic [cice_pkg::POS_BITS-1:0] i_beg,
    input  logic [cice_pkg::POS_BITS-1:0] i_end,
    output logic [cice_pkg::BIN_BITS-1:0] o_bin
);
    import cice_pkg::*;

    always_comb begin
        o_bin = '0;
        for (int j = N_LVLS - 1; j >= 0; j--) begin
            if ((i_beg >> (BASE_SHIFT + 3 * j)) == (i_end >> (BASE_SHIFT + 3 * j))) begin
                o_bin = bin_offset(N_LVLS - j)
                      + BIN_BITS'(i_beg >> (BASE_SHIFT + 3 * j));
            end
        end
    end

endmodule

/* rtl/csi_index_chunk_emitter.sv */
// An accepted item is held in the input register, then its chunks are written
// into the three-entry chunk buffer, whose head drives the result port.
// Throughput: one chunk per cycle while i_out_stall is low; an item yields up
// to three chunks; the next item advances as the last buffered chunk is taken.
// Reset: synchronous, active low; clears all index state and empties the
// input register and chunk buffer.
module csi_index_chunk_emitter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cice_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cice_pkg::t_out_item  o_out_item
);
    import cice_pkg::*;

    logic                     r_in_valid;
    t_in_item                 r_in;

    logic                     r_prev_seq_valid;
    logic [SEQ_BITS-1:0]      r_prev_seq;
    logic                     r_prev_bin_valid;
    logic [BIN_BITS-1:0]      r_prev_bin;
    logic                     r_saved_bin_valid;
    logic [BIN_BITS-1:0]      r_saved_bin;
    logic [SEQ_BITS-1:0]      r_saved_seq;
    logic [OFF_BITS-1:0]      r_saved_offset;
    logic [OFF_BITS-1:0]      r_seq_start_offset;
    logic [CNT_BITS-1:0]      r_seq_record_count;

    t_out_item                r_buf [MAX_CHUNKS];
    logic [CNT_IDX_BITS-1:0]  r_cnt;

    t_out_item                n_buf [MAX_CHUNKS];
    logic [CNT_IDX_BITS-1:0]  n_cnt;

    logic                     out_take;
    logic                     advance;
    logic                     in_accept;

    logic [SEQ_BITS-1:0]      seq;
    logic [POS_BITS-1:0]      beg_c;
    logic [POS_BITS-1:0]      endm1_c;
    logic [BIN_BITS-1:0]      bin;
    logic                     seq_chg;
    logic                     bin_chg;
    logic [CNT_BITS-1:0]      cnt_base;
    logic [OFF_BITS-1:0]      off;
    t_out_item                ck_saved;
    t_out_item                ck_span;
    t_out_item                ck_count;

    localparam logic signed [39:0] MAX_POS = 40'(64'd1 << POS_BITS);

    assign out_take    = (r_cnt != '0) && !i_out_stall;
    assign advance     = r_in_valid && ((r_cnt == '0) ||
                         ((r_cnt == CNT_IDX_BITS'(1)) && out_take));
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_buf[0];

    assign off = r_in.rec_offset;
    assign seq = r_in.seq_id & SEQ_MASK;

    always_comb begin
        if (r_in.reg_start < 40'sd0) begin
            beg_c = '0;
        end else if (r_in.reg_start > MAX_POS - 40'sd1) begin
            beg_c = '1;
        end else begin
            beg_c = r_in.reg_start[POS_BITS-1:0];
        end
        if (r_in.reg_end <= 40'sd0) begin
            endm1_c = '0;
        end else if (r_in.reg_end > MAX_POS) begin
            endm1_c = '1;
        end else begin
            endm1_c = POS_BITS'(r_in.reg_end - 40'sd1);
        end
    end

    cice_bin_calc u_bin (
        .i_beg (beg_c),
        .i_end (endm1_c),
        .o_bin (bin)
    );

    assign seq_chg  = !r_prev_seq_valid || (r_prev_seq != seq);
    assign bin_chg  = seq_chg || !r_prev_bin_valid || (r_prev_bin != bin);
    assign cnt_base = seq_chg ? '0 : r_seq_record_count;

    always_comb begin
        ck_saved = '{chunk_seq: r_saved_seq, chunk_bin: r_saved_bin,
                     chunk_beg: r_saved_offset, chunk_end: off, last_of_run: 1'b0};
        ck_span  = '{chunk_seq: r_prev_seq, chunk_bin: PSEUDO_BIN,
                     chunk_beg: r_seq_start_offset, chunk_end: off, last_of_run: 1'b0};
        ck_count = '{chunk_seq: r_prev_seq, chunk_bin: PSEUDO_BIN,
                     chunk_beg: OFF_BITS'(r_seq_record_count), chunk_end: '0,
                     last_of_run: 1'b0};
    end

    always_comb begin
        n_buf[0] = r_buf[1];
        n_buf[1] = r_buf[2];
        n_buf[2] = r_buf[2];
        n_cnt    = r_cnt;
        if (advance) begin
            n_cnt = '0;
            if (r_in.req_type == REQ_FINISH) begin
                if (r_saved_bin_valid) begin
                    n_buf[0] = ck_saved;
                    n_buf[1] = ck_span;
                    n_buf[2] = ck_count;
                    n_buf[2].last_of_run = 1'b1;
                    n_cnt = CNT_IDX_BITS'(3);
                end
            end else if (seq_chg && r_prev_seq_valid) begin
                n_buf[0] = ck_span;
                n_buf[1] = ck_count;
                n_buf[2] = ck_saved;
                if (bin_chg && r_saved_bin_valid) begin
                    n_buf[2].last_of_run = 1'b1;
                    n_cnt = CNT_IDX_BITS'(3);
                end else begin
                    n_buf[1].last_of_run = 1'b1;
                    n_cnt = CNT_IDX_BITS'(2);
                end
            end else if (bin_chg && r_saved_bin_valid) begin
                n_buf[0] = ck_saved;
                n_buf[0].last_of_run = 1'b1;
                n_cnt = CNT_IDX_BITS'(1);
            end
        end else if (out_take) begin
            n_cnt = r_cnt - CNT_IDX_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
        if (advance || out_take) begin
            for (int k = 0; k < MAX_CHUNKS; k++) begin
                r_buf[k] <= n_buf[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_cnt              <= '0;
            r_prev_seq_valid   <= 1'b0;
            r_prev_seq         <= '0;
            r_prev_bin_valid   <= 1'b0;
            r_prev_bin         <= '0;
            r_saved_bin_valid  <= 1'b0;
            r_saved_bin        <= '0;
            r_saved_seq        <= '0;
            r_saved_offset     <= '0;
            r_seq_start_offset <= '0;
            r_seq_record_count <= '0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
            r_cnt      <= n_cnt;
            if (advance) begin
                if (r_in.req_type == REQ_FINISH) begin
                    r_prev_seq_valid   <= 1'b0;
                    r_prev_seq         <= '0;
                    r_prev_bin_valid   <= 1'b0;
                    r_prev_bin         <= '0;
                    r_saved_bin_valid  <= 1'b0;
                    r_saved_bin        <= '0;
                    r_saved_seq        <= '0;
                    r_saved_offset     <= '0;
                    r_seq_start_offset <= '0;
                    r_seq_record_count <= '0;
                end else begin
                    if (seq_chg) begin
                        r_seq_start_offset <= off;
                        r_prev_seq         <= seq;
                        r_prev_seq_valid   <= 1'b1;
                    end
                    r_seq_record_count <= (cnt_base == CNT_MAX) ? cnt_base
                                        : cnt_base + CNT_BITS'(1);
                    if (bin_chg) begin
                        r_saved_offset    <= off;
                        r_saved_bin       <= bin;
                        r_prev_bin        <= bin;
                        r_saved_bin_valid <= 1'b1;
                        r_prev_bin_valid  <= 1'b1;
                        r_saved_seq       <= seq;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_csi_index_chunk_emitter.sv */
`timescale 1ns / 100ps

module tb_csi_index_chunk_emitter;
    import cice_pkg::*;

    localparam logic signed [39:0] NEG_MOST  = 40'sh80_0000_0000;
    localparam logic signed [39:0] POS_MOST  = 40'sh7F_FFFF_FFFF;
    localparam longint             POS_LIMIT = 64'sd1 <<< POS_BITS;

    typedef struct {
        t_in_item  req;
        int        n_typed;
        t_out_item c0;
        t_out_item c1;
        t_out_item c2;
    } t_probe;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          failed = 1'b0;

    t_out_item chunk_queue [$];
    t_out_item step_chunks [$];
    t_probe    probes [$];

    logic                seq_open;
    logic [SEQ_BITS-1:0] cur_seq;
    logic                bin_open;
    logic [BIN_BITS-1:0] cur_bin;
    logic                run_open;
    logic [BIN_BITS-1:0] run_bin;
    logic [SEQ_BITS-1:0] run_seq;
    logic [OFF_BITS-1:0] run_beg;
    logic [OFF_BITS-1:0] seq_beg;
    logic [CNT_BITS-1:0] seq_count;

    longint              walk_pos;
    logic [SEQ_BITS-1:0] walk_seq;

    csi_index_chunk_emitter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("csi_index_chunk_emitter test failed");
        $finish;
    end

    function automatic t_in_item mk_req(input logic kind, input logic [SEQ_BITS-1:0] seq,
                                        input logic signed [39:0] rs,
                                        input logic signed [39:0] re,
                                        input logic [OFF_BITS-1:0] off);
        return {kind, seq, rs, re, off};
    endfunction

    function automatic t_out_item mk_chunk(input logic [SEQ_BITS-1:0] seq,
                                           input logic [BIN_BITS-1:0] bin,
                                           input logic [OFF_BITS-1:0] beg,
                                           input logic [OFF_BITS-1:0] fin,
                                           input logic last);
        return {seq, bin, beg, fin, last};
    endfunction

    function automatic t_probe row(input t_in_item req, input int n_typed,
                                   input t_out_item c0 = '0, input t_out_item c1 = '0,
                                   input t_out_item c2 = '0);
        t_probe p;
        p.req     = req;
        p.n_typed = n_typed;
        p.c0      = c0;
        p.c1      = c1;
        p.c2      = c2;
        return p;
    endfunction

    function automatic void add_probe(input t_probe p);
        probes.insert(probes.size(), p);
    endfunction

    function automatic void note_chunk(input t_out_item c);
        step_chunks.insert(step_chunks.size(), c);
    endfunction

    function automatic void want_chunk(input t_out_item c);
        chunk_queue.insert(chunk_queue.size(), c);
    endfunction

    function automatic void clear_index();
        seq_open  = 1'b0;
        cur_seq   = '0;
        bin_open  = 1'b0;
        cur_bin   = '0;
        run_open  = 1'b0;
        run_bin   = '0;
        run_seq   = '0;
        run_beg   = '0;
        seq_beg   = '0;
        seq_count = '0;
    endfunction

    function automatic logic [BIN_BITS-1:0] csi_bin(input logic [63:0] lo,
                                                    input logic [63:0] hi);
        int sh;
        for (int lvl = N_LVLS; lvl > 0; lvl--) begin
            sh = BASE_SHIFT + 3 * (N_LVLS - lvl);
            if ((lo >> sh) == (hi >> sh)) begin
                return BIN_BITS'((((64'd1 << (3 * lvl)) - 64'd1) / 64'd7) + (lo >> sh));
            end
        end
        return '0;
    endfunction

    function automatic void index_step(input t_in_item it);
        logic [SEQ_BITS-1:0] seq;
        longint              b;
        longint              e;
        logic [BIN_BITS-1:0] bin;
        step_chunks.delete();
        if (it.req_type == REQ_FINISH) begin
            if (run_open) begin
                note_chunk(mk_chunk(run_seq, run_bin, run_beg, it.rec_offset, 1'b0));
                note_chunk(mk_chunk(cur_seq, PSEUDO_BIN, seq_beg, it.rec_offset, 1'b0));
                note_chunk(mk_chunk(cur_seq, PSEUDO_BIN, 64'(seq_count), '0, 1'b0));
            end
            clear_index();
        end else begin
            seq = it.seq_id & SEQ_MASK;
            b = {{24{it.reg_start[39]}}, it.reg_start};
            e = {{24{it.reg_end[39]}}, it.reg_end};
            if (b < 0) b = 0;
            if (b > POS_LIMIT - 1) b = POS_LIMIT - 1;
            if (e <= 0) e = 1;
            if (e > POS_LIMIT) e = POS_LIMIT;
            if (!seq_open || cur_seq != seq) begin
                if (seq_open) begin
                    note_chunk(mk_chunk(cur_seq, PSEUDO_BIN, seq_beg, it.rec_offset, 1'b0));
                    note_chunk(mk_chunk(cur_seq, PSEUDO_BIN, 64'(seq_count), '0, 1'b0));
                end
                seq_beg   = it.rec_offset;
                seq_count = '0;
                cur_seq   = seq;
                seq_open  = 1'b1;
                bin_open  = 1'b0;
            end
            if (seq_count != CNT_MAX) seq_count = seq_count + CNT_BITS'(1);
            bin = csi_bin(64'(b), 64'(e - 1));
            if (!bin_open || cur_bin != bin) begin
                if (run_open) begin
                    note_chunk(mk_chunk(run_seq, run_bin, run_beg, it.rec_offset, 1'b0));
                end
                run_beg  = it.rec_offset;
                run_bin  = bin;
                cur_bin  = bin;
                run_seq  = seq;
                run_open = 1'b1;
                bin_open = 1'b1;
            end
        end
        if (step_chunks.size() != 0) step_chunks[step_chunks.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic t_in_item next_random_item();
        t_in_item    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it.rec_offset = {$urandom, $urandom};
        if (pick < 4) begin
            it.req_type  = REQ_FINISH;
            it.seq_id    = SEQ_BITS'($urandom);
            it.reg_start = {8'($urandom), $urandom};
            it.reg_end   = {8'($urandom), $urandom};
            walk_seq     = SEQ_BITS'($urandom);
            walk_pos     = 0;
            return it;
        end
        it.req_type = REQ_RECORD;
        if (pick < 10) begin
            walk_seq = SEQ_BITS'($urandom);
            walk_pos = 0;
        end else if (pick < 14) begin
            walk_seq = walk_seq + SEQ_BITS'(1);
        end else if (pick < 18) begin
            walk_pos = longint'({$urandom, $urandom} >> 26);
        end
        it.seq_id = walk_seq;
        if (pick >= 94) begin
            it.reg_start = {8'($urandom), $urandom};
            it.reg_end   = {8'($urandom), $urandom};
        end else begin
            walk_pos = walk_pos + $urandom_range(0, 4000);
            it.reg_start = 40'(walk_pos);
            if ($urandom_range(0, 9) == 0) begin
                it.reg_end = 40'(walk_pos + $urandom_range(1, 1 << 20));
            end else begin
                it.reg_end = 40'(walk_pos + $urandom_range(1, 300));
            end
        end
        return it;
    endfunction

    function automatic void check_chunk(input t_out_item got);
        t_out_item want;
        if (chunk_queue.size() == 0) begin
            $error("unexpected chunk seq %0h bin %0d", got.chunk_seq, got.chunk_bin);
            failed = 1'b1;
            return;
        end
        want = chunk_queue.pop_front();
        if (got.chunk_seq !== want.chunk_seq) begin
            $error("chunk_seq expected %0h actual %0h", want.chunk_seq, got.chunk_seq);
            failed = 1'b1;
        end
        if (got.chunk_bin !== want.chunk_bin) begin
            $error("chunk_bin expected %0d actual %0d", want.chunk_bin, got.chunk_bin);
            failed = 1'b1;
        end
        if (got.chunk_beg !== want.chunk_beg) begin
            $error("chunk_beg expected %0h actual %0h", want.chunk_beg, got.chunk_beg);
            failed = 1'b1;
        end
        if (got.chunk_end !== want.chunk_end) begin
            $error("chunk_end expected %0h actual %0h", want.chunk_end, got.chunk_end);
            failed = 1'b1;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run expected %0b actual %0b", want.last_of_run, got.last_of_run);
            failed = 1'b1;
        end
    endfunction

    task automatic push_request(input t_probe p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= p.req;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        index_step(p.req);
        if (p.n_typed < 0) begin
            foreach (step_chunks[k]) want_chunk(step_chunks[k]);
        end else begin
            if (p.n_typed > 0) want_chunk(p.c0);
            if (p.n_typed > 1) want_chunk(p.c1);
            if (p.n_typed > 2) want_chunk(p.c2);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) check_chunk(out_item);
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin
        clear_index();
        walk_pos = 0;
        walk_seq = '0;

        add_probe(row(mk_req(REQ_FINISH, 12'hFFF, NEG_MOST, POS_MOST, '1), 0));
        add_probe(row(mk_req(REQ_RECORD, 12'h000, 40'sd0, 40'sd1, 64'h100), 0));
        add_probe(row(mk_req(REQ_RECORD, 12'h000, 40'sd0, 40'sd1, 64'h200), 0));
        add_probe(row(mk_req(REQ_RECORD, 12'h000, NEG_MOST, NEG_MOST, 64'h300), 0));
        add_probe(row(mk_req(REQ_RECORD, 12'h000, 40'sd16384, 40'sd16385, 64'h400), 1,
                      mk_chunk(12'h000, 25'd2396745, 64'h100, 64'h400, 1'b1)));
        add_probe(row(mk_req(REQ_RECORD, 12'hFFF, POS_MOST, POS_MOST, 64'h500), 3,
                      mk_chunk(12'h000, PSEUDO_BIN, 64'h100, 64'h500, 1'b0),
                      mk_chunk(12'h000, PSEUDO_BIN, 64'd4, 64'd0, 1'b0),
                      mk_chunk(12'h000, 25'd2396746, 64'h400, 64'h500, 1'b1)));
        add_probe(row(mk_req(REQ_FINISH, 12'h000, 40'sd0, 40'sd0, '1), 3,
                      mk_chunk(12'hFFF, 25'd19173960, 64'h500, '1, 1'b0),
                      mk_chunk(12'hFFF, PSEUDO_BIN, 64'h500, '1, 1'b0),
                      mk_chunk(12'hFFF, PSEUDO_BIN, 64'd1, 64'd0, 1'b1)));
        add_probe(row(mk_req(REQ_FINISH, 12'h000, 40'sd0, 40'sd0, 64'h700), 0));
        add_probe(row(mk_req(REQ_RECORD, 12'h5A5, 40'sd0, 40'sd1, '1), 0));
        add_probe(row(mk_req(REQ_RECORD, 12'h5A5, 40'sd0, 40'sd0, 64'h0), -1));
        add_probe(row(mk_req(REQ_RECORD, 12'h5A5, 40'sd1000000, 40'sd10, 64'h1234), -1));
        add_probe(row(mk_req(REQ_RECORD, 12'h5A5, 40'sd5000000, 40'sd5000000, 64'h2345),
                      -1));
        add_probe(row(mk_req(REQ_RECORD, 12'h5A5, -40'sd1, POS_MOST, 64'h3456), -1));
        add_probe(row(mk_req(REQ_RECORD, 12'h5A5, 40'sh40_0000_0000, 40'sh40_0000_0005,
                             64'h4567), -1));
        add_probe(row(mk_req(REQ_RECORD, 12'hA5A, 40'sh55_5555_5555, 40'sh2A_AAAA_AAAA,
                             64'hAAAA_AAAA_AAAA_AAAA), -1));
        add_probe(row(mk_req(REQ_RECORD, 12'hA5A, 40'sh55_5555_5555, 40'sh2A_AAAA_AAAA,
                             64'h5555_5555_5555_5555), -1));
        add_probe(row(mk_req(REQ_FINISH, 12'h000, 40'sd0, 40'sd0, 64'h5555_0000_5555),
                      -1));
        add_probe(row(mk_req(REQ_RECORD, 12'h123, 40'sd100, 40'sd200, 64'h1000), -1));
        add_probe(row(mk_req(REQ_FINISH, 12'h321, NEG_MOST, NEG_MOST, 64'h2000), -1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (probes[i]) push_request(probes[i]);

        // sweep idle mixes: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            repeat (108) push_request(row(next_random_item(), -1));
        end
        in_valid <= 1'b0;

        // drain outstanding chunks
        while (chunk_queue.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (!failed) begin
            $display("csi_index_chunk_emitter test passed");
        end else begin
            $display("csi_index_chunk_emitter test failed");
        end
        $finish;
    end

endmodule
